// ----- rtl/dce_pkg.sv -----
// Shared types, codes and constants for the 2D color key DMA engine.
`timescale 1ns / 1ps
`default_nettype none

package dce_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 16;
	localparam int DATA_W  = 64;
	localparam int IDX_W   = 3;
	localparam int OUT_W   = 136;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_ELEMENT = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SRC_BASE  = 3'd0,
		REG_DST_BASE  = 3'd1,
		REG_XFER_CTL  = 3'd2,
		REG_EXTENT    = 3'd3,
		REG_SRC_STEPS = 3'd4,
		REG_DST_STEPS = 3'd5,
		REG_COLOR_KEY = 3'd6,
		REG_KEY_CTL   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		WIDTH_BYTE  = 2'd0,
		WIDTH_HALF  = 2'd1,
		WIDTH_WORD  = 2'd2,
		WIDTH_DWORD = 2'd3
	} width_code_t;

	localparam int CTL_IRQ_EN  = 18;
	localparam int CTL_TWO_D   = 19;
	localparam int CTL_SRC_INC = 16;
	localparam int CTL_DST_INC = 17;

	typedef struct packed {
		logic [31:0] src_base;
		logic [31:0] dst_base;
		logic [19:0] xfer_ctl;
		logic [31:0] extent;
		logic [63:0] src_steps;
		logic [63:0] dst_steps;
		logic [31:0] color_key;
		logic [4:0]  key_ctl;
	} cfg_t;

	typedef struct packed {
		logic              read_request;
		logic [31:0]       read_addr;
		logic [1:0]        read_width_code;
		logic              write_enable;
		logic [31:0]       write_addr;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        write_width_code;
		logic              busy_res;
		logic              done_res;
		logic              irq_pending;
	} result_t;

	function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
		logic [DATA_W-1:0] m;
		case (code)
			WIDTH_BYTE:  m = 64'h0000_0000_0000_00ff;
			WIDTH_HALF:  m = 64'h0000_0000_0000_ffff;
			WIDTH_WORD:  m = 64'h0000_0000_ffff_ffff;
			WIDTH_DWORD: m = 64'hffff_ffff_ffff_ffff;
			default:     m = 64'hffff_ffff_ffff_ffff;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dce_cfg_regs.sv -----
// Configuration register file of the 2D color key DMA engine.
`timescale 1ns / 1ps
`default_nettype none

module dce_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [dce_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [dce_pkg::DATA_W-1:0]   cfg_wdata,
	output dce_pkg::cfg_t                     cfg
);
	import dce_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_index))
				REG_SRC_BASE:  cfg_q.src_base  <= cfg_wdata[31:0];
				REG_DST_BASE:  cfg_q.dst_base  <= cfg_wdata[31:0];
				REG_XFER_CTL:  cfg_q.xfer_ctl  <= cfg_wdata[19:0];
				REG_EXTENT:    cfg_q.extent    <= cfg_wdata[31:0];
				REG_SRC_STEPS: cfg_q.src_steps <= cfg_wdata;
				REG_DST_STEPS: cfg_q.dst_steps <= cfg_wdata;
				REG_COLOR_KEY: cfg_q.color_key <= cfg_wdata[31:0];
				REG_KEY_CTL:   cfg_q.key_ctl   <= cfg_wdata[4:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/dce_core.sv -----
// Transfer state and combinational element processing of the DMA engine.
`timescale 1ns / 1ps
`default_nettype none

module dce_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire dce_pkg::cfg_t              cfg,
	input  wire logic                       advance,
	input  wire logic [1:0]                 cmd,
	input  wire logic [dce_pkg::DATA_W-1:0] read_data,
	output dce_pkg::result_t                res
);
	import dce_pkg::*;

	logic [ADDR_W-1:0]  src_q, dst_q, src_n, dst_n;
	logic [COUNT_W-1:0] col_q, row_q, col_n, row_n;
	logic               busy_q, irq_q, busy_n, irq_n;

	logic               two_d, irq_en, start, elem, done, wen, keyed;
	logic [1:0]         sw, dw;
	logic [COUNT_W-1:0] xcount, ycount, lcount, col_inc, row_inc;
	logic [ADDR_W-1:0]  src_x, dst_x;
	logic [DATA_W-1:0]  value;
	logic [31:0]        key_mask;

	always_comb begin
		two_d   = cfg.xfer_ctl[CTL_TWO_D];
		irq_en  = cfg.xfer_ctl[CTL_IRQ_EN];
		sw      = cfg.xfer_ctl[13:12];
		dw      = two_d ? sw : cfg.xfer_ctl[15:14];
		xcount  = cfg.extent[COUNT_W-1:0];
		ycount  = cfg.extent[16 +: COUNT_W];
		lcount  = COUNT_W'(cfg.xfer_ctl[11:0]);
		start   = (cmd_t'(cmd) == CMD_START) && !busy_q;
		elem    = (cmd_t'(cmd) == CMD_ELEMENT) && busy_q;
		col_inc = col_q + COUNT_W'(1);
		row_inc = row_q + COUNT_W'(1);
		src_x   = src_q + ADDR_W'(cfg.src_steps[31:0]);
		dst_x   = dst_q + ADDR_W'(cfg.dst_steps[31:0]);
		value   = read_data & width_mask(sw);

		key_mask = {{8{cfg.key_ctl[4]}}, {8{cfg.key_ctl[3]}},
			{8{cfg.key_ctl[2]}}, {8{cfg.key_ctl[1]}}};
		keyed = cfg.key_ctl[0] && (((value[31:0] ^ cfg.color_key) & key_mask) == 32'd0);
		wen   = !keyed;

		src_n  = src_q;
		dst_n  = dst_q;
		col_n  = col_q;
		row_n  = row_q;
		busy_n = busy_q;
		irq_n  = irq_q;
		done   = 1'b0;

		if (start) begin
			src_n  = ADDR_W'(cfg.src_base);
			dst_n  = ADDR_W'(cfg.dst_base);
			col_n  = '0;
			row_n  = '0;
			busy_n = 1'b1;
			done   = two_d ? (xcount == '0 || ycount == '0) : (lcount == '0);
		end else if (elem) begin
			col_n = col_inc;
			if (two_d) begin
				src_n = src_x;
				dst_n = dst_x;
				if (col_inc == xcount) begin
					col_n = '0;
					src_n = src_x + ADDR_W'(cfg.src_steps[63:32]);
					dst_n = dst_x + ADDR_W'(cfg.dst_steps[63:32]);
					row_n = row_inc;
					done  = (row_inc == ycount);
				end
			end else begin
				if (cfg.xfer_ctl[CTL_SRC_INC]) begin
					src_n = src_q + (ADDR_W'(1) << sw);
				end
				if (cfg.xfer_ctl[CTL_DST_INC]) begin
					dst_n = dst_q + (ADDR_W'(1) << dw);
				end
				done = (col_inc == lcount);
			end
		end else if (cmd_t'(cmd) == CMD_CLEAR) begin
			irq_n = 1'b0;
		end

		if (done) begin
			busy_n = 1'b0;
			if (irq_en) begin
				irq_n = 1'b1;
			end
		end

		res.read_request     = busy_n;
		res.read_addr        = busy_n ? src_n[31:0] : 32'd0;
		res.read_width_code  = busy_n ? sw : 2'd0;
		res.write_enable     = elem && wen;
		res.write_addr       = elem ? dst_q[31:0] : 32'd0;
		res.write_data       = elem ? (value & width_mask(dw)) : '0;
		res.write_width_code = elem ? dw : 2'd0;
		res.busy_res         = busy_n;
		res.done_res         = done;
		res.irq_pending      = irq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= '0;
			dst_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			busy_q <= 1'b0;
			irq_q  <= 1'b0;
		end else if (advance) begin
			src_q  <= src_n;
			dst_q  <= dst_n;
			col_q  <= col_n;
			row_q  <= row_n;
			busy_q <= busy_n;
			irq_q  <= irq_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dma_2d_color_key_engine_unit.sv -----
// Top level of the 2D color key DMA engine: stream ports and pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

// One channel, linear or 2D, with color keying of destination writes. Every command
// transfer yields exactly one result transfer. A command is captured in an input
// register and processed in one pass (at most two chained 32-bit cursor adds and the
// end-of-row compare) into a result register, and one command is taken every cycle
// while the result side keeps up. The result register parts the two sides; tready
// on the command side follows the result side only when both registers are full.
// Configuration writes take effect the next cycle.

module dma_2d_color_key_engine_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic [dce_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [dce_pkg::DATA_W-1:0]   cfg_wdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// read_data[63:0]
	input  wire logic [63:0]                  s_tdata,
	// command[1:0]
	input  wire logic [1:0]                   s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// read_request[0], read_addr[32:1], read_width_code[34:33], write_enable[35],
	// write_addr[67:36], write_data[131:68], write_width_code[133:132],
	// busy_res[134], irq_pending[135]
	output logic [dce_pkg::OUT_W-1:0]         m_tdata,
	// done_res
	output logic                              m_tlast
);
	import dce_pkg::*;

	cfg_t              cfg;
	result_t           res, res_q;
	logic              valid_s1, out_valid_q, advance;
	logic [1:0]        cmd_s1;
	logic [DATA_W-1:0] rdata_s1;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	dce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dce_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.advance   (advance),
		.cmd       (cmd_s1),
		.read_data (rdata_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tuser;
			rdata_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.done_res;
	assign m_tdata  = {res_q.irq_pending, res_q.busy_res, res_q.write_width_code,
		res_q.write_data, res_q.write_addr, res_q.write_enable,
		res_q.read_width_code, res_q.read_addr, res_q.read_request};

`ifndef SYNTH
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !res_q.busy_res)
		else $error("done result still reports busy");

	a_write_needs_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.write_enable && !m_tlast |-> res_q.busy_res)
		else $error("write outside of an active transfer");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("input register lost a pending command");
`endif

endmodule

`default_nettype wire

// ----- bench/dma_2d_color_key_engine_unit_tb.sv -----
// Self-checking testbench for the 2D color key DMA engine: directed and random command streams.
`timescale 1ns / 1ps

module dma_2d_color_key_engine_unit_tb;

	import dce_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [DATA_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// read_data[63:0]
	logic [63:0]         s_tdata = '0;
	// command[1:0]
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// read_request[0], read_addr[32:1], read_width_code[34:33], write_enable[35],
	// write_addr[67:36], write_data[131:68], write_width_code[133:132],
	// busy_res[134], irq_pending[135]
	logic [OUT_W-1:0]    m_tdata;
	// done_res
	logic                m_tlast;

	dma_2d_color_key_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Register shadow and channel state as the engine should hold them.
	cfg_t        shadow = '0;
	logic [31:0] rd_cursor = '0;
	logic [31:0] wr_cursor = '0;
	logic [15:0] col_count = '0;
	logic [15:0] row_count = '0;
	logic        xfer_busy = 1'b0;
	logic        irq_flag = 1'b0;

	result_t     due_results[$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	int          src_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          hold_go = 1'b0;
	int          hold_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] elem_mask(input logic [1:0] code);
		if (code == WIDTH_DWORD)
			return '1;
		return (64'd1 << (8 << code)) - 64'd1;
	endfunction

	function automatic logic [31:0] lane_bits(input logic [3:0] strobes);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 4; i++)
			if (strobes[i])
				m[8*i +: 8] = 8'hff;
		return m;
	endfunction

	function automatic logic key_hit(input logic [31:0] v);
		logic [31:0] m;
		m = lane_bits(shadow.key_ctl[4:1]);
		if (!shadow.key_ctl[0])
			return 1'b0;
		return (v & m) == (shadow.color_key & m);
	endfunction

	function automatic result_t dma_step(input cmd_t cmd, input logic [63:0] rd);
		result_t     r;
		logic        two_d;
		logic [1:0]  sw;
		logic [1:0]  dw;
		logic [15:0] xcnt;
		logic [15:0] ycnt;
		logic [15:0] lcnt;
		logic [63:0] value;
		logic        done;
		r = '0;
		done = 1'b0;
		two_d = shadow.xfer_ctl[CTL_TWO_D];
		sw = shadow.xfer_ctl[13:12];
		dw = two_d ? sw : shadow.xfer_ctl[15:14];
		xcnt = shadow.extent[15:0];
		ycnt = shadow.extent[31:16];
		lcnt = {4'd0, shadow.xfer_ctl[11:0]};
		if (cmd == CMD_START && !xfer_busy) begin
			rd_cursor = shadow.src_base;
			wr_cursor = shadow.dst_base;
			col_count = '0;
			row_count = '0;
			xfer_busy = 1'b1;
			if (two_d ? (xcnt == 0 || ycnt == 0) : (lcnt == 0))
				done = 1'b1;
		end else if (cmd == CMD_ELEMENT && xfer_busy) begin
			value = rd & elem_mask(sw);
			r.write_addr = wr_cursor;
			r.write_data = value & elem_mask(dw);
			r.write_width_code = dw;
			r.write_enable = !key_hit(value[31:0]);
			col_count = col_count + 16'd1;
			if (two_d) begin
				rd_cursor = rd_cursor + shadow.src_steps[31:0];
				wr_cursor = wr_cursor + shadow.dst_steps[31:0];
				if (col_count == xcnt) begin
					col_count = '0;
					rd_cursor = rd_cursor + shadow.src_steps[63:32];
					wr_cursor = wr_cursor + shadow.dst_steps[63:32];
					row_count = row_count + 16'd1;
					if (row_count == ycnt)
						done = 1'b1;
				end
			end else begin
				if (shadow.xfer_ctl[CTL_SRC_INC])
					rd_cursor = rd_cursor + (32'd1 << sw);
				if (shadow.xfer_ctl[CTL_DST_INC])
					wr_cursor = wr_cursor + (32'd1 << dw);
				if (col_count == lcnt)
					done = 1'b1;
			end
		end else if (cmd == CMD_CLEAR) begin
			irq_flag = 1'b0;
		end
		if (done) begin
			xfer_busy = 1'b0;
			if (shadow.xfer_ctl[CTL_IRQ_EN])
				irq_flag = 1'b1;
		end
		if (xfer_busy) begin
			r.read_request = 1'b1;
			r.read_addr = rd_cursor;
			r.read_width_code = sw;
		end
		r.busy_res = xfer_busy;
		r.done_res = done;
		r.irq_pending = irq_flag;
		return r;
	endfunction

	function automatic logic [19:0] make_ctl(input logic [11:0] count, input logic [1:0] sw,
			input logic [1:0] dw, input logic src_inc, input logic dst_inc, input logic irq_en,
			input logic two_d);
		logic [19:0] c;
		c = '0;
		c[11:0] = count;
		c[13:12] = sw;
		c[15:14] = dw;
		c[CTL_SRC_INC] = src_inc;
		c[CTL_DST_INC] = dst_inc;
		c[CTL_IRQ_EN] = irq_en;
		c[CTL_TWO_D] = two_d;
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'hffff_fff0 | $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic cfg_t random_setup();
		cfg_t s;
		s.src_base = pick_addr();
		s.dst_base = pick_addr();
		s.xfer_ctl = make_ctl(($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 12)),
			2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		s.extent = {16'($urandom_range(0, 4)), 16'($urandom_range(0, 4))};
		if ($urandom_range(9) != 0 && s.extent[15:0] == 0)
			s.extent[15:0] = 16'd1;
		if ($urandom_range(9) != 0 && s.extent[31:16] == 0)
			s.extent[31:16] = 16'd1;
		s.src_steps = rand64();
		s.dst_steps = rand64();
		if ($urandom_range(1))
			s.src_steps = {32'($signed(-$urandom_range(64))), 32'($signed(-$urandom_range(8)))};
		s.color_key = $urandom;
		s.key_ctl = 5'($urandom_range(31));
		return s;
	endfunction

	function automatic logic [63:0] element_data();
		logic [63:0] d;
		logic [31:0] m;
		d = rand64();
		m = lane_bits(shadow.key_ctl[4:1]);
		case ($urandom_range(9))
			0: d = '0;
			1: d = '1;
			2, 3, 4: d[31:0] = (shadow.color_key & m) | (d[31:0] & ~m);
			default: ;
		endcase
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 20)
			$display("mismatch in %s: got %h, expected %h (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] td, input logic last);
		result_t want;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected result transfer", td[63:0], '0);
		end else begin
			want = due_results.pop_front();
			if (td[0] !== want.read_request)
				report_mismatch("read_request", td[0], want.read_request);
			if (td[32:1] !== want.read_addr)
				report_mismatch("read_addr", td[32:1], want.read_addr);
			if (td[34:33] !== want.read_width_code)
				report_mismatch("read_width_code", td[34:33], want.read_width_code);
			if (td[35] !== want.write_enable)
				report_mismatch("write_enable", td[35], want.write_enable);
			if (td[67:36] !== want.write_addr)
				report_mismatch("write_addr", td[67:36], want.write_addr);
			if (td[131:68] !== want.write_data)
				report_mismatch("write_data", td[131:68], want.write_data);
			if (td[133:132] !== want.write_width_code)
				report_mismatch("write_width_code", td[133:132], want.write_width_code);
			if (td[134] !== want.busy_res)
				report_mismatch("busy_res", td[134], want.busy_res);
			if (last !== want.done_res)
				report_mismatch("done_res", last, want.done_res);
			if (td[135] !== want.irq_pending)
				report_mismatch("irq_pending", td[135], want.irq_pending);
		end
	endtask

	// Result side: checks each transfer and drives tready with random stalls or a long hold.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			check_result(m_tdata, m_tlast);
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_cmd(input cmd_t cmd, input logic [63:0] data);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		due_results.push_back(dma_step(cmd, data));
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [63:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Only called with the pipeline empty.
	task automatic load_setup(input cfg_t s);
		put_reg(REG_SRC_BASE, 64'(s.src_base));
		put_reg(REG_DST_BASE, 64'(s.dst_base));
		put_reg(REG_XFER_CTL, 64'(s.xfer_ctl));
		put_reg(REG_EXTENT, 64'(s.extent));
		put_reg(REG_SRC_STEPS, s.src_steps);
		put_reg(REG_DST_STEPS, s.dst_steps);
		put_reg(REG_COLOR_KEY, 64'(s.color_key));
		put_reg(REG_KEY_CTL, 64'(s.key_ctl));
		cfg_wen <= 1'b0;
		shadow = s;
	endtask

	task automatic finish_transfer();
		while (xfer_busy)
			send_cmd(CMD_ELEMENT, element_data());
	endtask

	task automatic test_directed_linear();
		cfg_t s;
		s = '0;
		s.src_base = 32'hffff_fff8;
		s.xfer_ctl = make_ctl(12'd3, WIDTH_DWORD, WIDTH_BYTE, 1'b1, 1'b1, 1'b1, 1'b0);
		s.color_key = 32'hdead_beef;
		s.key_ctl = 5'b11111;
		drain();
		load_setup(s);
		send_cmd(CMD_ELEMENT, '1);
		send_cmd(CMD_NONE, '1);
		send_cmd(CMD_CLEAR, '0);
		send_cmd(CMD_START, '0);
		send_cmd(CMD_START, '1);
		send_cmd(CMD_ELEMENT, '0);
		send_cmd(CMD_ELEMENT, '1);
		send_cmd(CMD_ELEMENT, 64'h0123_4567_dead_beef);
		send_cmd(CMD_CLEAR, '1);
	endtask

	task automatic test_empty_transfers();
		cfg_t s;
		s = '0;
		s.xfer_ctl = make_ctl(12'd0, WIDTH_WORD, WIDTH_HALF, 1'b1, 1'b0, 1'b1, 1'b0);
		s.extent = 32'h0003_0003;
		drain();
		load_setup(s);
		send_cmd(CMD_START, '0);
		s.xfer_ctl = make_ctl(12'd5, WIDTH_WORD, WIDTH_HALF, 1'b1, 1'b0, 1'b0, 1'b1);
		s.extent = 32'h0003_0000;
		drain();
		load_setup(s);
		send_cmd(CMD_START, '0);
		s.extent = 32'h0000_0003;
		drain();
		load_setup(s);
		send_cmd(CMD_START, '0);
		send_cmd(CMD_CLEAR, '0);
	endtask

	task automatic test_2d_negative_steps();
		cfg_t s;
		s = '0;
		s.src_base = 32'h0000_0004;
		s.dst_base = 32'h8000_0000;
		s.xfer_ctl = make_ctl(12'hfff, WIDTH_HALF, WIDTH_DWORD, 1'b0, 1'b0, 1'b0, 1'b1);
		s.extent = 32'h0002_0002;
		s.src_steps = {32'hffff_fff0, 32'h0000_0002};
		s.dst_steps = {32'h0000_0100, 32'hffff_fffc};
		s.key_ctl = 5'b00001;
		drain();
		load_setup(s);
		send_cmd(CMD_START, '0);
		repeat (4)
			send_cmd(CMD_ELEMENT, rand64());
	endtask

	task automatic test_key_strobes();
		cfg_t s;
		s = '0;
		s.src_base = 32'h0000_1000;
		s.dst_base = 32'h0000_2000;
		s.xfer_ctl = make_ctl(12'd2, WIDTH_WORD, WIDTH_HALF, 1'b0, 1'b0, 1'b1, 1'b0);
		s.color_key = 32'h00aa_00bb;
		s.key_ctl = {4'b0101, 1'b1};
		drain();
		load_setup(s);
		send_cmd(CMD_START, '0);
		send_cmd(CMD_ELEMENT, 64'h0000_0000_11aa_22bb);
		send_cmd(CMD_ELEMENT, 64'hffff_ffff_11aa_22bc);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_items);
		int sent;
		drain();
		src_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 40) begin
				drain();
				load_setup(random_setup());
			end
			send_cmd(CMD_START, rand64());
			sent++;
			while (xfer_busy) begin
				if ($urandom_range(99) < 8) begin
					send_cmd(cmd_t'($urandom_range(3)), rand64());
					sent++;
				end
				send_cmd(CMD_ELEMENT, element_data());
				sent++;
			end
			if ($urandom_range(99) < 40) begin
				send_cmd(CMD_CLEAR, rand64());
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_output_backpressure();
		cfg_t s;
		drain();
		src_idle_pct = 0;
		rx_stall_pct = 0;
		s = random_setup();
		s.xfer_ctl = make_ctl(12'd20, 2'($urandom_range(3)), 2'($urandom_range(3)), 1'b1,
			1'b1, 1'b1, 1'b0);
		load_setup(s);
		hold_go = 1'b1;
		send_cmd(CMD_START, rand64());
		finish_transfer();
		drain();
	endtask

	task automatic test_extreme_counts();
		cfg_t s;
		drain();
		src_idle_pct = 0;
		rx_stall_pct = 0;
		// The longest linear count is left running; only its first elements are sent.
		s = random_setup();
		s.xfer_ctl = make_ctl(12'hfff, 2'($urandom_range(3)), 2'($urandom_range(3)), 1'b1,
			1'b1, 1'b1, 1'b0);
		load_setup(s);
		send_cmd(CMD_START, rand64());
		repeat (30)
			send_cmd(CMD_ELEMENT, element_data());
		// The largest 2D extent is loaded under the running transfer, so its start is ignored.
		s = random_setup();
		s.xfer_ctl = make_ctl(12'd0, WIDTH_DWORD, WIDTH_BYTE, 1'b0, 1'b0, 1'b1, 1'b1);
		s.extent = 32'hffff_ffff;
		drain();
		load_setup(s);
		send_cmd(CMD_START, rand64());
		repeat (30)
			send_cmd(CMD_ELEMENT, element_data());
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_linear();
		test_empty_transfers();
		test_2d_negative_steps();
		test_key_strobes();
		test_random_traffic(0, 0, 180);
		test_random_traffic(51, 0, 180);
		test_random_traffic(0, 51, 180);
		test_random_traffic(35, 35, 180);
		test_output_backpressure();
		test_extreme_counts();
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
